@@ src/region_access_checker_macros.svh @@
// Assertion macros shared by the region access checker RTL.
// Depends on nothing; included by the controller and the datapath.
`ifndef REGION_ACCESS_CHECKER_MACROS_SVH
`define REGION_ACCESS_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion, muted while reset is asserted
`define RAC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("region_access_checker: assertion failed");

// Clocked assertion that also holds during reset
`define RAC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("region_access_checker: assertion failed");

`else

`define RAC_ASSERT(lbl, clk, rst_n, prop)
`define RAC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ src/rac_pkg.sv @@
// Shared types and constants of the region access checker.
// No dependencies; imported by every module of the block.
package rac_pkg;

    localparam int MAX_REGIONS = 8;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W      = 32;
    localparam int KIND_W      = 2;

    typedef enum logic [2:0] {
        ACT_CHECK   = 3'd0,
        ACT_ADD     = 3'd1,
        ACT_REMOVE  = 3'd2,
        ACT_ENABLE  = 3'd3,
        ACT_DISABLE = 3'd4,
        ACT_CLEAR   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ARG   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    localparam logic [KIND_W-1:0] KIND_READ_ONLY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NO_ACCESS = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_APPLY
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming transaction
        logic lookup;   // register the per-region match vectors
        logic apply;    // update table and load result register
    } t_cmd;

endpackage

@@ src/rac_ctrl.sv @@
// Controller of the region access checker: sequencing and handshakes.
// Depends on rac_pkg and region_access_checker_macros.svh.
`include "region_access_checker_macros.svh"

module rac_ctrl
    import rac_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                cmd.lookup = 1'b1;
                n_state    = S_APPLY;
            end
            S_APPLY: begin
                // wait until the result register is free or being drained
                if (!r_out_valid || i_m_tready) begin
                    cmd.apply = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (cmd.apply) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = cmd;

    `RAC_ASSERT(a_accept_goes_lookup, i_clk, i_rst_n,
        (i_s_tvalid && o_s_tready) |=> (r_state == S_LOOKUP))
    `RAC_ASSERT(a_apply_shows_result, i_clk, i_rst_n,
        cmd.apply |=> r_out_valid)
    `RAC_ASSERT(a_blocked_apply_waits, i_clk, i_rst_n,
        (r_state == S_APPLY && r_out_valid && !i_m_tready) |=> (r_state == S_APPLY))

endmodule

@@ src/rac_datapath.sv @@
// Datapath of the region access checker: region table, per-region
// comparators, result logic and result register. Depends on rac_pkg and
// region_access_checker_macros.svh.
`include "region_access_checker_macros.svh"

module rac_datapath
    import rac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic [2:0]        i_action,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [ADDR_W-1:0] i_region_size,
    input  logic [KIND_W-1:0] i_region_type,
    input  logic              i_is_write,
    output logic [1:0]        o_status,
    output logic              o_allowed,
    output logic              o_fault,
    output logic              o_fault_write
);

    // Fault-report register
    logic r_fault_en;

    // Captured transaction
    t_action           r_act;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_size;
    logic [KIND_W-1:0] r_type;
    logic              r_wr;

    // Region table
    logic [ADDR_W-1:0] r_start [MAX_REGIONS];
    logic [ADDR_W-1:0] r_len   [MAX_REGIONS];
    logic [KIND_W-1:0] r_kind  [MAX_REGIONS];
    logic              r_on    [MAX_REGIONS];
    logic [CNT_W-1:0]  r_count;

    // Match vectors
    logic [MAX_REGIONS-1:0] hit_vec, eq_vec;
    logic [MAX_REGIONS-1:0] r_hit_vec, r_eq_vec;
    logic [MAX_REGIONS-1:0] first_hit, first_eq, shift_mask;

    // Result registers
    t_status r_status;
    logic    r_allowed, r_fault, r_fwrite;

    t_status           res_status;
    logic              res_allowed, res_fault, res_fwrite;
    logic              hit_found, eq_found, table_ok;
    logic [KIND_W-1:0] hit_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_fault_en <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= t_action'(i_action);
            r_addr <= i_address;
            r_size <= i_region_size;
            r_type <= i_region_type;
            r_wr   <= i_is_write;
        end
    end

    // One comparator lane per region: 33-bit end, no wraparound
    always_comb begin
        for (int k = 0; k < MAX_REGIONS; k++) begin
            logic             live;
            logic [ADDR_W:0]  hi;
            live       = CNT_W'(k) < r_count;
            hi         = {1'b0, r_start[k]} + {1'b0, r_len[k]};
            hit_vec[k] = live && r_on[k] && (r_addr >= r_start[k]) &&
                         ({1'b0, r_addr} < hi);
            eq_vec[k]  = live && (r_start[k] == r_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit_vec <= hit_vec;
            r_eq_vec  <= eq_vec;
        end
    end

    // First-match one-hots and the shift mask for remove
    always_comb begin
        logic seen_hit, seen_eq;
        seen_hit = 1'b0;
        seen_eq  = 1'b0;
        hit_kind = '0;
        for (int k = 0; k < MAX_REGIONS; k++) begin
            first_hit[k]  = r_hit_vec[k] && !seen_hit;
            first_eq[k]   = r_eq_vec[k] && !seen_eq;
            seen_hit      = seen_hit | r_hit_vec[k];
            seen_eq       = seen_eq | r_eq_vec[k];
            shift_mask[k] = seen_eq;
            hit_kind      = hit_kind | (first_hit[k] ? r_kind[k] : '0);
        end
        hit_found = seen_hit;
        eq_found  = seen_eq;
    end

    // Result of the current transaction
    always_comb begin
        res_status  = ST_OK;
        res_allowed = 1'b1;
        res_fault   = 1'b0;
        res_fwrite  = 1'b0;
        case (r_act)
            ACT_CHECK: begin
                if (hit_found && ((hit_kind == KIND_READ_ONLY && r_wr) ||
                                  hit_kind == KIND_NO_ACCESS)) begin
                    res_allowed = 1'b0;
                    res_fault   = r_fault_en;
                    res_fwrite  = r_fault_en & r_wr;
                end
            end
            ACT_ADD: begin
                if (r_addr == '0 || r_size == '0) begin
                    res_status = ST_BAD_ARG;
                end else if (r_count >= CNT_W'(MAX_REGIONS)) begin
                    res_status = ST_FULL;
                end
            end
            ACT_REMOVE, ACT_ENABLE, ACT_DISABLE: begin
                if (!eq_found) begin
                    res_status = ST_NOT_FOUND;
                end
            end
            ACT_CLEAR: res_status = ST_OK;
            default:   res_status = ST_BAD_ARG;
        endcase
        table_ok = i_cmd.apply && (res_status == ST_OK);
    end

    // Table lanes; entries above the count are kept zero
    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_lane
        logic [ADDR_W-1:0] up_start, up_len;
        logic [KIND_W-1:0] up_kind;
        logic              up_on;

        if (g < MAX_REGIONS - 1) begin : g_up
            assign up_start = r_start[g+1];
            assign up_len   = r_len[g+1];
            assign up_kind  = r_kind[g+1];
            assign up_on    = r_on[g+1];
        end else begin : g_top
            assign up_start = '0;
            assign up_len   = '0;
            assign up_kind  = '0;
            assign up_on    = 1'b0;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_start[g] <= '0;
                r_len[g]   <= '0;
                r_kind[g]  <= '0;
                r_on[g]    <= 1'b0;
            end else if (table_ok) begin
                case (r_act)
                    ACT_ADD: begin
                        if (CNT_W'(g) == r_count) begin
                            r_start[g] <= r_addr;
                            r_len[g]   <= r_size;
                            r_kind[g]  <= r_type;
                            r_on[g]    <= 1'b1;
                        end
                    end
                    ACT_REMOVE: begin
                        if (shift_mask[g]) begin
                            r_start[g] <= up_start;
                            r_len[g]   <= up_len;
                            r_kind[g]  <= up_kind;
                            r_on[g]    <= up_on;
                        end
                    end
                    ACT_ENABLE, ACT_DISABLE: begin
                        if (first_eq[g]) begin
                            r_on[g] <= (r_act == ACT_ENABLE);
                        end
                    end
                    ACT_CLEAR: begin
                        r_start[g] <= '0;
                        r_len[g]   <= '0;
                        r_kind[g]  <= '0;
                        r_on[g]    <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (table_ok) begin
            case (r_act)
                ACT_ADD:    r_count <= r_count + CNT_W'(1);
                ACT_REMOVE: r_count <= r_count - CNT_W'(1);
                ACT_CLEAR:  r_count <= '0;
                default:    r_count <= r_count;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_status  <= res_status;
            r_allowed <= res_allowed;
            r_fault   <= res_fault;
            r_fwrite  <= res_fwrite;
        end
    end

    assign o_status      = r_status;
    assign o_allowed     = r_allowed;
    assign o_fault       = r_fault;
    assign o_fault_write = r_fwrite;

    `RAC_ASSERT_ALWAYS(a_count_bound, i_clk,
        !i_rst_n || (r_count <= CNT_W'(MAX_REGIONS)))
    `RAC_ASSERT(a_single_hit, i_clk, i_rst_n,
        i_cmd.apply |-> ($onehot0(first_hit) && $onehot0(first_eq)))
    `RAC_ASSERT(a_clear_empties, i_clk, i_rst_n,
        (i_cmd.apply && r_act == ACT_CLEAR) |=> (r_count == '0))

endmodule

@@ src/region_access_checker.sv @@
// Top level of the region access checker: stream ports and config port.
// Depends on rac_pkg, rac_ctrl and rac_datapath.
//
//  channel   | direction | tdata / tuser contents
//  ----------+-----------+------------------------------------------------
//  s (in)    | slave     | tuser: action; tdata: address, size, type, write
//  m (out)   | master    | tdata: status, allowed, fault, fault_write
//  cfg       | write     | i_cfg_wdata: fault_report_enable
//
// Each transaction goes through capture, region compare (all regions in
// parallel, 33-bit end), then table update and result load; a new input is
// taken in the cycle after that, so one transaction ends before the next enters.
// The result register lets a new input enter while a result is still held;
// the update stage stalls only while that held result is not taken.
// Synchronous active-low reset empties the table and clears fault reporting.
module region_access_checker
    import rac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // address[31:0], region_size[63:32],
                                     // region_type[65:64], is_write[66], zeros
    input  logic [2:0]  i_s_tuser,   // action[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // status[1:0], allowed[2], fault[3],
                                     // fault_write[4], zeros
);

    t_cmd       cmd;
    logic [1:0] status;
    logic       allowed, fault, fault_write;

    rac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    rac_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_action      (i_s_tuser),
        .i_address     (i_s_tdata[31:0]),
        .i_region_size (i_s_tdata[63:32]),
        .i_region_type (i_s_tdata[65:64]),
        .i_is_write    (i_s_tdata[66]),
        .o_status      (status),
        .o_allowed     (allowed),
        .o_fault       (fault),
        .o_fault_write (fault_write)
    );

    assign o_m_tdata = {3'b000, fault_write, fault, allowed, status};

endmodule

@@ dv/rac_verdict_pkg.sv @@
// Scoreboard for the region access checker testbench: a region table
// predictor and the queue of expected verdicts. Depends on rac_pkg.
package rac_verdict_pkg;
    import rac_pkg::*;

    // Action codes the block does not define, plus the kinds rac_pkg leaves unnamed
    localparam logic [2:0]        ACT_SPARE_LO    = 3'd6;
    localparam logic [2:0]        ACT_SPARE_HI    = 3'd7;
    localparam logic [KIND_W-1:0] KIND_NONE       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ_WRITE = 2'd2;

    // Output transaction layout, lowest bits last
    typedef struct packed {
        logic [2:0] pad;
        logic       fault_write;
        logic       fault;
        logic       allowed;
        t_status    status;
    } t_verdict;

    class region_verdict_board;
        logic [ADDR_W-1:0] reg_start [MAX_REGIONS];
        logic [ADDR_W-1:0] reg_len   [MAX_REGIONS];
        logic [KIND_W-1:0] reg_kind  [MAX_REGIONS];
        bit                reg_on    [MAX_REGIONS];
        int                reg_count;
        bit                fault_en;
        t_verdict          verdicts_due [$];
        int                mismatches;
        int                n_requests;
        int                n_checks;
        int                n_denied;
        int                n_faults;
        int                n_full;
        int                n_missing;

        function new();
            wipe();
            fault_en   = 1'b0;
            mismatches = 0;
            n_requests = 0;
            n_checks   = 0;
            n_denied   = 0;
            n_faults   = 0;
            n_full     = 0;
            n_missing  = 0;
        endfunction

        function void wipe();
            for (int k = 0; k < MAX_REGIONS; k++) begin
                reg_start[k] = '0;
                reg_len[k]   = '0;
                reg_kind[k]  = '0;
                reg_on[k]    = 1'b0;
            end
            reg_count = 0;
        endfunction

        // First entry, enabled or not, starting at a
        function int find_start(logic [ADDR_W-1:0] a);
            for (int k = 0; k < reg_count; k++) begin
                if (reg_start[k] == a) return k;
            end
            return -1;
        endfunction

        // First enabled entry holding a; the end carries one extra bit
        function int find_hit(logic [ADDR_W-1:0] a);
            logic [ADDR_W:0] hi;
            for (int k = 0; k < reg_count; k++) begin
                hi = {1'b0, reg_start[k]} + {1'b0, reg_len[k]};
                if (reg_on[k] && a >= reg_start[k] && {1'b0, a} < hi) return k;
            end
            return -1;
        endfunction

        // Expected verdict of one request; updates the table copy
        function t_verdict predict_verdict(logic [2:0] act, logic [ADDR_W-1:0] addr,
                                           logic [ADDR_W-1:0] size,
                                           logic [KIND_W-1:0] kind, logic wr);
            t_verdict v;
            int       k;
            v = '{pad: 3'b000, fault_write: 1'b0, fault: 1'b0, allowed: 1'b1,
                  status: ST_OK};
            case (act)
                ACT_CHECK: begin
                    n_checks++;
                    k = find_hit(addr);
                    if (k >= 0 && ((reg_kind[k] == KIND_READ_ONLY && wr) ||
                                   reg_kind[k] == KIND_NO_ACCESS)) begin
                        v.allowed = 1'b0;
                        n_denied++;
                        if (fault_en) begin
                            v.fault       = 1'b1;
                            v.fault_write = wr;
                            n_faults++;
                        end
                    end
                end
                ACT_ADD: begin
                    if (addr == '0 || size == '0) begin
                        v.status = ST_BAD_ARG;
                    end else if (reg_count >= MAX_REGIONS) begin
                        v.status = ST_FULL;
                        n_full++;
                    end else begin
                        reg_start[reg_count] = addr;
                        reg_len[reg_count]   = size;
                        reg_kind[reg_count]  = kind;
                        reg_on[reg_count]    = 1'b1;
                        reg_count++;
                    end
                end
                ACT_REMOVE: begin
                    k = find_start(addr);
                    if (k < 0) begin
                        v.status = ST_NOT_FOUND;
                        n_missing++;
                    end else begin
                        for (int j = k; j < reg_count - 1; j++) begin
                            reg_start[j] = reg_start[j+1];
                            reg_len[j]   = reg_len[j+1];
                            reg_kind[j]  = reg_kind[j+1];
                            reg_on[j]    = reg_on[j+1];
                        end
                        reg_count--;
                        reg_start[reg_count] = '0;
                        reg_len[reg_count]   = '0;
                        reg_kind[reg_count]  = '0;
                        reg_on[reg_count]    = 1'b0;
                    end
                end
                ACT_ENABLE, ACT_DISABLE: begin
                    k = find_start(addr);
                    if (k < 0) begin
                        v.status = ST_NOT_FOUND;
                        n_missing++;
                    end else begin
                        reg_on[k] = (act == ACT_ENABLE);
                    end
                end
                ACT_CLEAR: wipe();
                default:   v.status = ST_BAD_ARG;
            endcase
            return v;
        endfunction

        function void note_request(logic [2:0] act, logic [ADDR_W-1:0] addr,
                                   logic [ADDR_W-1:0] size,
                                   logic [KIND_W-1:0] kind, logic wr);
            n_requests++;
            verdicts_due.push_back(predict_verdict(act, addr, size, kind, wr));
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        // Compare one output transaction with the oldest expected verdict
        task check_verdict(logic [7:0] raw);
            t_verdict got;
            t_verdict want;
            got = t_verdict'(raw);
            if (verdicts_due.size() == 0) begin
                flag_mismatch("result with no request pending", 32'(raw), 32'd0);
                return;
            end
            want = verdicts_due.pop_front();
            if (got.status !== want.status)
                flag_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.allowed !== want.allowed)
                flag_mismatch("allowed", 32'(got.allowed), 32'(want.allowed));
            if (got.fault !== want.fault)
                flag_mismatch("fault", 32'(got.fault), 32'(want.fault));
            if (got.fault_write !== want.fault_write)
                flag_mismatch("fault_write", 32'(got.fault_write),
                              32'(want.fault_write));
            if (got.pad !== want.pad)
                flag_mismatch("tdata padding", 32'(got.pad), 32'(want.pad));
        endtask
    endclass

endpackage

@@ dv/tb_region_access_checker.sv @@
// Top of the region access checker testbench: clock, reset, stream drivers,
// monitor and watchdog. Depends on rac_pkg, rac_verdict_pkg and the RTL.
module tb_region_access_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import rac_pkg::*;
    import rac_verdict_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 295;
    localparam int PHASES         = 6;
    localparam int DRAIN_CYCLES   = 8;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata   = '0;   // address[31:0], region_size[63:32],
                                     // region_type[65:64], is_write[66], zeros
    logic [2:0]  i_s_tuser   = '0;   // action[2:0]
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;          // status[1:0], allowed[2], fault[3],
                                     // fault_write[4], zeros

    region_access_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    region_verdict_board board;
    bit src_idle_on = 1'b0;
    bit snk_idle_on = 1'b0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side backpressure
    always @(posedge i_clk) begin
        i_m_tready <= !snk_idle_on || ($urandom_range(99) >= 35);
    end

    // Monitor: results are checked before the same edge's request is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                board.check_verdict(o_m_tdata);
            if (i_s_tvalid && o_s_tready)
                board.note_request(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32],
                                   i_s_tdata[65:64], i_s_tdata[66]);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_region_access_checker failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Present one request and hold it until accepted; returns on the accepting edge
    task automatic send_item(input logic [2:0] act, input logic [31:0] addr,
                             input logic [31:0] size, input logic [1:0] kind,
                             input logic wr);
        bit ready_seen;
        while (src_idle_on && $urandom_range(99) < 35) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {5'b0, wr, kind, size, addr};
        do begin
            @(negedge i_clk);
            ready_seen = o_s_tready;
            @(posedge i_clk);
        end while (!ready_seen);
    endtask

    // Let every verdict come back, then write fault reporting
    task automatic drain_and_configure(input bit value);
        i_s_tvalid <= 1'b0;
        // let the monitor note the last accepted request first
        @(posedge i_clk);
        while (board.verdicts_due.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        board.fault_en = value;
    endtask

    // Random request, mostly aimed at the regions currently in the table
    task automatic send_random_item();
        logic [2:0]  act;
        logic [31:0] addr;
        logic [31:0] size;
        logic [1:0]  kind;
        logic        wr;
        logic [32:0] top;
        int          pick;
        int          slot;
        pick = $urandom_range(99);
        addr = $urandom;
        size = $urandom;
        kind = 2'($urandom_range(3));
        wr   = 1'($urandom_range(1));
        slot = (board.reg_count > 0) ? $urandom_range(board.reg_count - 1) : -1;
        if (pick < 55)      act = ACT_CHECK;
        else if (pick < 72) act = ACT_ADD;
        else if (pick < 80) act = ACT_REMOVE;
        else if (pick < 87) act = ACT_ENABLE;
        else if (pick < 94) act = ACT_DISABLE;
        else if (pick < 97) act = ACT_CLEAR;
        else                act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;

        case (act)
            ACT_CHECK: begin
                if (slot >= 0 && $urandom_range(99) < 70) begin
                    top = {1'b0, board.reg_start[slot]} + {1'b0, board.reg_len[slot]};
                    case ($urandom_range(3))
                        0: addr = board.reg_start[slot];
                        // last byte, clipped to the top of the address space
                        1: addr = top[32] ? 32'hFFFF_FFFF : top[31:0] - 32'd1;
                        2: addr = top[31:0];
                        default: addr = board.reg_start[slot] +
                                        ($urandom % board.reg_len[slot]);
                    endcase
                end
            end
            ACT_ADD: begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    addr = '0;
                end else if (pick < 10) begin
                    size = '0;
                end else if (pick < 20) begin
                    addr[31:12] = '1;          // near the top, large size crosses it
                end else if (pick < 30 && slot >= 0) begin
                    addr = board.reg_start[slot];
                    size = $urandom_range(4096, 1);
                end else if (pick < 85) begin
                    size = $urandom_range(4096, 1);
                end
            end
            ACT_REMOVE, ACT_ENABLE, ACT_DISABLE: begin
                if (slot >= 0 && $urandom_range(99) < 80)
                    addr = board.reg_start[slot];
            end
            default: ;
        endcase
        send_item(act, addr, size, kind, wr);
    endtask

    initial begin
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, fault reporting on
        drain_and_configure(1'b1);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        send_item(ACT_CHECK,  32'h0000_0000, 32'h0000_0000, KIND_NONE,      1'b1);
        send_item(ACT_ADD,    32'h0000_0000, 32'h0000_0010, KIND_READ_ONLY, 1'b0);
        send_item(ACT_ADD,    32'h0000_1000, 32'h0000_0000, KIND_READ_ONLY, 1'b0);
        send_item(ACT_ADD,    32'h0000_1000, 32'h0000_0100, KIND_READ_ONLY, 1'b0);
        send_item(ACT_ADD,    32'h0000_2000, 32'h0000_0100, KIND_NO_ACCESS, 1'b0);
        send_item(ACT_ADD,    32'hFFFF_FF00, 32'h0000_0200, KIND_NO_ACCESS, 1'b0);
        // same start again, wider and read-write
        send_item(ACT_ADD,    32'h0000_1000, 32'h0001_0000, KIND_READ_WRITE, 1'b0);
        send_item(ACT_CHECK,  32'h0000_1000, 32'hFFFF_FFFF, KIND_NO_ACCESS, 1'b1);
        send_item(ACT_CHECK,  32'h0000_10FF, 32'h0000_0000, KIND_NONE,      1'b0);
        send_item(ACT_CHECK,  32'h0000_1100, 32'h0000_0000, KIND_NONE,      1'b1);
        send_item(ACT_CHECK,  32'h0000_20FF, 32'h0000_0000, KIND_NONE,      1'b0);
        send_item(ACT_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, KIND_NONE,      1'b1);
        // region past the top must not wrap round to low addresses
        send_item(ACT_CHECK,  32'h0000_0050, 32'h0000_0000, KIND_NONE,      1'b1);
        send_item(ACT_DISABLE, 32'h0000_1000, 32'h0, KIND_NONE, 1'b0);
        send_item(ACT_CHECK,  32'h0000_1000, 32'h0000_0000, KIND_NONE,      1'b1);
        send_item(ACT_ENABLE, 32'h0000_3000, 32'h0, KIND_NONE, 1'b0);
        send_item(ACT_REMOVE, 32'h0000_1000, 32'h0, KIND_NONE, 1'b0);
        // fill the table, then one more add
        send_item(ACT_ADD,    32'h0000_4000, 32'h0000_0001, KIND_NONE,      1'b0);
        send_item(ACT_ADD,    32'h0000_5000, 32'hFFFF_FFFF, KIND_READ_ONLY, 1'b1);
        send_item(ACT_ADD,    32'h0000_6000, 32'h0000_0010, KIND_READ_WRITE, 1'b0);
        send_item(ACT_ADD,    32'h0000_7000, 32'h0000_0010, KIND_NO_ACCESS, 1'b0);
        send_item(ACT_ADD,    32'h0000_8000, 32'h0000_0010, KIND_READ_ONLY, 1'b0);
        send_item(ACT_ADD,    32'h0000_9000, 32'h0000_0010, KIND_READ_WRITE, 1'b0);
        send_item(ACT_SPARE_LO, 32'h0000_2000, 32'h10, KIND_READ_ONLY, 1'b1);
        send_item(ACT_SPARE_HI, 32'h0000_2000, 32'h10, KIND_READ_ONLY, 1'b1);
        send_item(ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_NO_ACCESS, 1'b1);
        send_item(ACT_CHECK,  32'h0000_2000, 32'h0000_0000, KIND_NONE,      1'b1);

        // Random phases; one of them runs with no idling on either side
        for (int p = 0; p < PHASES; p++) begin
            drain_and_configure((p < 4) ? p[0] : 1'($urandom_range(1)));
            src_idle_on = (p != 2);
            snk_idle_on = (p != 2);
            repeat (PHASE_ITEMS) send_random_item();
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests: %0d checks, %0d denied, %0d faults raised",
                 board.n_requests, board.n_checks, board.n_denied, board.n_faults);
        $display("table-full returns %0d, start-not-found returns %0d, mismatches %0d",
                 board.n_full, board.n_missing, board.mismatches);
        if (board.mismatches == 0) begin
            $display("tb_region_access_checker passed");
        end else begin
            $display("tb_region_access_checker failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/rac_pkg.sv
src/rac_ctrl.sv
src/rac_datapath.sv
src/region_access_checker.sv
dv/rac_verdict_pkg.sv
dv/tb_region_access_checker.sv
